/* src/grdc_pkg.sv */
// Package for the grid ray caster: item types, grid constants and helpers.
// Used by every module of the block; depends on nothing.
package grdc_pkg;

  localparam int GRID_SIZE = 8;
  localparam int SCREEN_COLUMNS = 640;
  localparam int CELL_W = $clog2(GRID_SIZE);
  localparam int MAP_W = GRID_SIZE * GRID_SIZE;
  localparam int IDX_W = 6;
  localparam int STEP_MAX = 2 * GRID_SIZE;
  localparam int STEP_W = $clog2(STEP_MAX + 2);
  localparam int DIV_BITS = 31;
  localparam int DIV_CELLS = 16;
  localparam int BITS_PER_CELL = 2;
  localparam int SD_W = 48;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;
  localparam logic [40:0] INF_STEP = 41'h100_0000_0000;
  // Reciprocal of the screen width for the column scale 2^17 / SCREEN_COLUMNS.
  localparam int CAM_SHIFT = 22;
  localparam longint CAM_RECIP =
    ((longint'(1) << (17 + CAM_SHIFT)) + SCREEN_COLUMNS - 1) / SCREEN_COLUMNS;

  typedef struct packed {
    logic [9:0] column;
    logic [14:0] view_x;
    logic [14:0] view_y;
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic signed [15:0] camera_x;
    logic signed [15:0] camera_y;
  } ray_in_t;

  typedef struct packed {
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic [23:0] wall_distance;
    logic face;
    logic [5:0] cell_index;
    logic [15:0] hit_fraction;
    logic escaped;
  } ray_out_t;

  // Partial divider state passed along the chain of divider cells, with the
  // divisor travelling beside it.
  typedef struct packed {
    logic [DIV_BITS-1:0] rem;
    logic [DIV_BITS-1:0] quo;
    logic [15:0] dvs;
  } div_pass_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RAY   = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SIDE  = 7'b0001000,
    S_WALK  = 7'b0010000,
    S_FRAC  = 7'b0100000,
    S_OUT   = 7'b1000000
  } fsm_t;

endpackage

/* src/grid_ray_dda_cast.sv */
// Top level of the grid ray caster: ray set-up, DDA walk and result register.
// Depends on grdc_pkg and grdc_div_chain.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | ray_in_t
//  out     | output    | out_valid/out_ready| ray_out_t
//  cfg     | input     | cfg_we             | 64-bit wall map
//
// Each item passes set-up, the divider stage (ray forming, then x and y in turn
// through the 16-cell chain), side distances, the DDA walk, the fraction and the
// result register. The length of the walk sets how long an item takes. The next
// item can be taken once the result is loaded and the controller is idle again.
// Reset returns the controller to idle with no item held. A stalled result
// holds in the output register; the next item is still taken and worked, and
// waits in the output state until the register is free.
module grid_ray_dda_cast (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  grdc_pkg::ray_in_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output grdc_pkg::ray_out_t out_data,
  input  logic cfg_we,
  input  logic [63:0] cfg_data
);
  import grdc_pkg::*;

  fsm_t state;
  logic [63:0] wall_map;
  ray_in_t item;
  logic signed [15:0] ray_x, ray_y;
  logic signed [34:0] prod_x, prod_y;
  logic signed [18:0] camq;
  logic [15:0] div_in;
  logic [DIV_BITS-1:0] div_q;
  logic [4:0] cnt;
  logic [40:0] ddx, ddy;
  logic [SD_W-1:0] sdx, sdy;
  logic [23:0] wall_dist;
  logic signed [CELL_W+1:0] mx, my;
  logic face, hit, esc;
  logic [IDX_W-1:0] idx;
  logic [STEP_W-1:0] nstep;
  logic signed [41:0] frac_prod;
  logic [15:0] fraction;
  logic out_load;

  // Column scale: 2*column*65536/SCREEN_COLUMNS - 65536, by reciprocal multiply.
  function automatic logic signed [18:0] cam_of(input logic [9:0] c);
    logic [39:0] num;
    num = 40'(c) * 40'(CAM_RECIP);
    return $signed({1'b0, num[39:CAM_SHIFT]}) - 19'sd65536;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [34:0] v);
    if (v > 35'sd32767) return 16'sh7FFF;
    if (v < -35'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : v;
  endfunction

  // Shared divider chain, fed x in the first issue cycle and y in the next.
  assign div_in = (cnt == 5'd1) ? mag16(ray_x) : mag16(ray_y);
  grdc_div_chain u_div (.clk(clk), .divisor(div_in), .quotient(div_q));

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  logic at_wall, off_grid;
  logic [IDX_W-1:0] cur_idx;
  assign cur_idx = IDX_W'(my * GRID_SIZE + mx);
  assign at_wall = wall_map[cur_idx];
  assign off_grid = mx < 0 || mx >= GRID_SIZE || my < 0 || my >= GRID_SIZE;

  // Hit coordinate along the wall face, taken on the other axis.
  assign fraction = 16'((face ? {item.view_y, 4'd0} : {item.view_x, 4'd0})
                        + 19'(frac_prod >>> 14));

  always_ff @(posedge clk) begin
    if (rst) wall_map <= '0;
    else if (cfg_we) wall_map <= cfg_data;
  end

  // Sequencer for one item.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            camq <= cam_of(in_data.column);
            state <= S_RAY;
          end
        end
        S_RAY: begin
          prod_x <= 35'(item.camera_x) * 35'(camq);
          prod_y <= 35'(item.camera_y) * 35'(camq);
          cnt <= 5'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 5'd0) begin
            ray_x <= sat16(35'(item.heading_x) + (prod_x >>> 16));
            ray_y <= sat16(35'(item.heading_y) + (prod_y >>> 16));
            cnt <= 5'd1;
          end else begin
            cnt <= cnt + 5'd1;
            if (cnt == 5'(DIV_CELLS + 1))
              ddx <= (ray_x == 0) ? INF_STEP : 41'(div_q);
            if (cnt == 5'(DIV_CELLS + 2)) begin
              ddy <= (ray_y == 0) ? INF_STEP : 41'(div_q);
              state <= S_SIDE;
            end
          end
        end
        S_SIDE: begin
          sdx <= SD_W'(((ray_x[15] ? 53'(item.view_x[11:0])
                       : 53'(13'd4096 - item.view_x[11:0])) * 53'(ddx)) >> 12);
          sdy <= SD_W'(((ray_y[15] ? 53'(item.view_y[11:0])
                       : 53'(13'd4096 - item.view_y[11:0])) * 53'(ddy)) >> 12);
          mx <= (CELL_W+2)'(item.view_x[14:12]);
          my <= (CELL_W+2)'(item.view_y[14:12]);
          esc <= (item.view_x[14:12] >= GRID_SIZE) || (item.view_y[14:12] >= GRID_SIZE);
          face <= 1'b0; wall_dist <= '0; hit <= 1'b0; nstep <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          // One DDA step per cycle; stop on wall, exit, or step bound.
          if (esc || off_grid) begin
            esc <= 1'b1; state <= S_FRAC;
          end else if (at_wall) begin
            hit <= 1'b1; idx <= cur_idx; state <= S_FRAC;
          end else if (nstep >= STEP_W'(STEP_MAX)) begin
            esc <= 1'b1; state <= S_FRAC;
          end else begin
            nstep <= nstep + 1'b1;
            if (sdx < sdy) begin
              wall_dist <= (sdx > SD_W'(DIST_MAX)) ? DIST_MAX : sdx[23:0];
              sdx <= sdx + SD_W'(ddx);
              mx <= ray_x[15] ? mx - 1'b1 : mx + 1'b1;
              face <= 1'b1;
            end else begin
              wall_dist <= (sdy > SD_W'(DIST_MAX)) ? DIST_MAX : sdy[23:0];
              sdy <= sdy + SD_W'(ddy);
              my <= ray_y[15] ? my - 1'b1 : my + 1'b1;
              face <= 1'b0;
            end
          end
        end
        S_FRAC: begin
          frac_prod <= $signed({1'b0, wall_dist}) * (face ? ray_y : ray_x);
          state <= S_OUT;
        end
        S_OUT: begin
          // The result waits here until the output register is free.
          if (out_load) begin
            out_data.ray_x <= ray_x;
            out_data.ray_y <= ray_y;
            out_data.escaped <= !hit;
            out_data.wall_distance <= hit ? wall_dist : DIST_MAX;
            out_data.face <= hit & face;
            out_data.cell_index <= hit ? idx : '0;
            out_data.hit_fraction <= hit ? fraction : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A waiting result stays valid and unchanged.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("result dropped");
  // A result only appears from the output state.
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT)) else $error("stray result");
  // A walk never exceeds its step bound.
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> nstep <= STEP_W'(STEP_MAX)) else $error("step bound");
endmodule

/* src/grdc_div_cell.sv */
// One cell of the restoring divider chain: retires two quotient bits.
// Depends on grdc_pkg.
module grdc_div_cell (
  input  logic clk,
  input  logic [grdc_pkg::BITS_PER_CELL-1:0] num_bits,
  input  grdc_pkg::div_pass_t pass_in,
  output grdc_pkg::div_pass_t pass_out
);
  import grdc_pkg::*;

  div_pass_t work;
  logic [DIV_BITS:0] trial;

  // Two dependent shift-subtract steps on the remainder.
  always_comb begin
    work = pass_in;
    trial = '0;
    for (int b = 0; b < BITS_PER_CELL; b++) begin
      trial = {work.rem, num_bits[BITS_PER_CELL-1-b]};
      work.rem = trial[DIV_BITS-1:0];
      if (trial >= {{(DIV_BITS-15){1'b0}}, work.dvs}) begin
        work.rem = trial[DIV_BITS-1:0] - {{(DIV_BITS-16){1'b0}}, work.dvs};
        work.quo = {work.quo[DIV_BITS-2:0], 1'b1};
      end else begin
        work.quo = {work.quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    pass_out <= work;
  end
endmodule

/* src/grdc_div_chain.sv */
// Chain of divider cells computing 2^30 / a for a 16-bit magnitude.
// Depends on grdc_pkg and grdc_div_cell.
module grdc_div_chain (
  input  logic clk,
  input  logic [15:0] divisor,
  output logic [grdc_pkg::DIV_BITS-1:0] quotient
);
  import grdc_pkg::*;

  // Numerator 2^30, fed most significant bit first, two bits per cell.
  localparam logic [2*DIV_CELLS-1:0] NUMER = (2*DIV_CELLS)'(longint'(1) << 30);

  div_pass_t link [DIV_CELLS+1];
  logic [BITS_PER_CELL-1:0] num_sh [DIV_CELLS];

  assign link[0] = '{rem: '0, quo: '0, dvs: divisor};

  // Each cell sees the numerator bits that belong to its position.
  for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
    localparam int SH = g * BITS_PER_CELL;
    assign num_sh[g] = NUMER[2*DIV_CELLS-1-SH -: BITS_PER_CELL];
    grdc_div_cell u_cell (
      .clk(clk), .num_bits(num_sh[g]),
      .pass_in(link[g]), .pass_out(link[g+1])
    );
  end

  assign quotient = link[DIV_CELLS].quo;
endmodule
